@@ hdl/mpt_pkg.sv @@
// Package for the member path tokenizer: character codes, result kinds,
// error codes, parse modes and default capacities. No dependencies.
package mpt_pkg;

    // Characters that steer the parser.
    localparam logic [7:0] CHAR_TERM    = 8'd0;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_OPEN    = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE   = 8'h5D;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'd48;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'd57;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_INDEX = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // Error codes.
    localparam logic [2:0] ERR_EMPTY        = 3'd0;
    localparam logic [2:0] ERR_LEAD_BRACKET = 3'd1;
    localparam logic [2:0] ERR_NO_CLOSE     = 3'd2;
    localparam logic [2:0] ERR_NOT_DIGIT    = 3'd3;
    localparam logic [2:0] ERR_NO_DIGITS    = 3'd4;
    localparam logic [2:0] ERR_AFTER_INDEX  = 3'd5;
    localparam logic [2:0] ERR_BAD_DOT      = 3'd6;
    localparam logic [2:0] ERR_CAPACITY     = 3'd7;

    // Parser state codes.
    localparam logic [1:0] MODE_NAME  = 2'd0;
    localparam logic [1:0] MODE_INDEX = 2'd1;
    localparam logic [1:0] MODE_ERROR = 2'd2;

    // Default capacities.
    localparam int DEF_MAX_SEGMENTS = 16;
    localparam int DEF_MAX_NAME_LEN = 32;
    localparam int DEF_MAX_DIMS     = 8;
    localparam int DEF_MAX_DIGITS   = 10;

endpackage

@@ hdl/member_path_tokenizer.sv @@
// Member path tokenizer top level: state registers, parse decisions and the
// output register. Depends on mpt_pkg and mpt_digit_acc.
//
// Usage: one path character enters per word on the s_ channel (s_valid,
// s_ready, s_char_in); byte 0 ends a path. Each character gives zero or one
// result word on the m_ channel: a name character with its segment and
// position, an array index when its closing bracket arrives, a done word
// carrying the segment count, or an error word with a code. After an error,
// characters give no words until the terminator, which always returns the
// parser to its start state.
// Output: a result is registered, on m_ the cycle after its character is taken.
// Throughput: one character per cycle while s_ready is high; each character
// is decided by one pass of classification and a times-ten add between the
// parser state registers and the output register.
// Stall: a held result word keeps its values while m_ready is low; a new
// character is still taken in the cycle in which the held word leaves.
// Reset: aresetn (synchronous, active low) empties the output register and
// puts the parser in name mode at segment zero.
module member_path_tokenizer
    import mpt_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int MAX_NAME_LEN = DEF_MAX_NAME_LEN,
    parameter int MAX_DIMS     = DEF_MAX_DIMS,
    parameter int MAX_DIGITS   = DEF_MAX_DIGITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [3:0]  m_segment_number,
    output logic [4:0]  m_position,
    output logic [31:0] m_payload,
    output logic [2:0]  m_error_code
);

    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
    localparam int LEN_W = $clog2(MAX_NAME_LEN + 1);
    localparam int DIM_W = $clog2(MAX_DIMS + 1);
    localparam int DIG_W = $clog2(MAX_DIGITS + 1);

    // Parser state.
    logic [1:0]       mode_reg,  mode_next;
    logic [SEG_W-1:0] seg_reg,   seg_next;
    logic [LEN_W-1:0] len_reg,   len_next;
    logic [DIM_W-1:0] dim_reg,   dim_next;
    logic [DIG_W-1:0] dig_reg,   dig_next;
    logic [31:0]      index_reg, index_next;

    // Output register.
    logic        out_valid_reg;
    logic [1:0]  kind_reg,    kind_next;
    logic [3:0]  segnum_reg;
    logic [4:0]  pos_reg,     pos_next;
    logic [31:0] payload_reg, payload_next;
    logic [2:0]  err_reg,     err_next;

    logic        emit;
    logic        fail;
    logic [2:0]  fail_code;
    logic        accept;
    logic        is_digit;
    logic [31:0] acc_value;
    logic        acc_overflow;
    logic [31:0] seg_wide;
    logic [31:0] len_wide;
    logic [31:0] dim_wide;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    mpt_digit_acc u_digit_acc (
        .value_in  (index_reg),
        .char_in   (s_char_in),
        .value_out (acc_value),
        .overflow  (acc_overflow)
    );

    // Parse decision for the current character.
    always_comb begin
        mode_next    = mode_reg;
        seg_next     = seg_reg;
        len_next     = len_reg;
        dim_next     = dim_reg;
        dig_next     = dig_reg;
        index_next   = index_reg;
        emit         = 1'b0;
        fail         = 1'b0;
        fail_code    = ERR_EMPTY;
        kind_next    = KIND_CHAR;
        pos_next     = '0;
        payload_next = '0;
        err_next     = ERR_EMPTY;
        seg_wide     = 32'(seg_reg);
        len_wide     = 32'(len_reg);
        dim_wide     = 32'(dim_reg);
        is_digit     = (s_char_in >= CHAR_DIGIT_0) && (s_char_in <= CHAR_DIGIT_9);

        unique case (mode_reg)
            MODE_INDEX: begin
                if (s_char_in == CHAR_TERM) begin
                    fail      = 1'b1;
                    fail_code = ERR_NO_CLOSE;
                end else if (s_char_in == CHAR_CLOSE) begin
                    if (dig_reg == '0) begin
                        fail      = 1'b1;
                        fail_code = ERR_NO_DIGITS;
                    end else begin
                        emit         = 1'b1;
                        kind_next    = KIND_INDEX;
                        pos_next     = dim_wide[4:0];
                        payload_next = index_reg;
                        dim_next     = dim_reg + 1'b1;
                        mode_next    = MODE_NAME;
                    end
                end else if (!is_digit) begin
                    fail      = 1'b1;
                    fail_code = ERR_NOT_DIGIT;
                end else if (dig_reg >= DIG_W'(MAX_DIGITS) || acc_overflow) begin
                    fail      = 1'b1;
                    fail_code = ERR_CAPACITY;
                end else begin
                    index_next = acc_value;
                    dig_next   = dig_reg + 1'b1;
                end
            end
            MODE_NAME: begin
                if (s_char_in == CHAR_TERM) begin
                    if (len_reg == '0) begin
                        fail      = 1'b1;
                        fail_code = ERR_EMPTY;
                    end else begin
                        emit         = 1'b1;
                        kind_next    = KIND_DONE;
                        payload_next = seg_wide + 32'd1;
                        mode_next    = MODE_NAME;
                        seg_next     = '0;
                        len_next     = '0;
                        dim_next     = '0;
                        dig_next     = '0;
                        index_next   = '0;
                    end
                end else if (s_char_in == CHAR_DOT) begin
                    if (len_reg == '0) begin
                        fail      = 1'b1;
                        fail_code = ERR_BAD_DOT;
                    end else if (seg_reg == SEG_W'(MAX_SEGMENTS - 1)) begin
                        fail      = 1'b1;
                        fail_code = ERR_CAPACITY;
                    end else begin
                        seg_next = seg_reg + 1'b1;
                        len_next = '0;
                        dim_next = '0;
                    end
                end else if (s_char_in == CHAR_OPEN) begin
                    if (len_reg == '0) begin
                        fail      = 1'b1;
                        fail_code = ERR_LEAD_BRACKET;
                    end else if (dim_reg >= DIM_W'(MAX_DIMS)) begin
                        fail      = 1'b1;
                        fail_code = ERR_CAPACITY;
                    end else begin
                        mode_next  = MODE_INDEX;
                        dig_next   = '0;
                        index_next = '0;
                    end
                end else if (dim_reg != '0) begin
                    fail      = 1'b1;
                    fail_code = ERR_AFTER_INDEX;
                end else if (len_reg >= LEN_W'(MAX_NAME_LEN)) begin
                    fail      = 1'b1;
                    fail_code = ERR_CAPACITY;
                end else begin
                    // Ordinary name character, a closing bracket included.
                    emit         = 1'b1;
                    kind_next    = KIND_CHAR;
                    pos_next     = len_wide[4:0];
                    payload_next = {24'd0, s_char_in};
                    len_next     = len_reg + 1'b1;
                end
            end
            default: begin
                // Error mode swallows characters until the terminator.
                if (s_char_in == CHAR_TERM) begin
                    mode_next  = MODE_NAME;
                    seg_next   = '0;
                    len_next   = '0;
                    dim_next   = '0;
                    dig_next   = '0;
                    index_next = '0;
                end
            end
        endcase

        // An error word; the terminator restarts, anything else enters error mode.
        if (fail) begin
            emit         = 1'b1;
            kind_next    = KIND_ERROR;
            pos_next     = '0;
            payload_next = {24'd0, s_char_in};
            err_next     = fail_code;
            if (s_char_in == CHAR_TERM) begin
                mode_next  = MODE_NAME;
                seg_next   = '0;
                len_next   = '0;
                dim_next   = '0;
                dig_next   = '0;
                index_next = '0;
            end else begin
                mode_next = MODE_ERROR;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NAME;
            seg_reg   <= '0;
            len_reg   <= '0;
            dim_reg   <= '0;
            dig_reg   <= '0;
            index_reg <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            seg_reg   <= seg_next;
            len_reg   <= len_next;
            dim_reg   <= dim_next;
            dig_reg   <= dig_next;
            index_reg <= index_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word fields.
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            kind_reg    <= kind_next;
            segnum_reg  <= seg_wide[3:0];
            pos_reg     <= pos_next;
            payload_reg <= payload_next;
            err_reg     <= err_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = kind_reg;
    assign m_segment_number = segnum_reg;
    assign m_position       = pos_reg;
    assign m_payload        = payload_reg;
    assign m_error_code     = err_reg;

endmodule

@@ hdl/mpt_digit_acc.sv @@
// Decimal index accumulator: value * 10 + digit with 32-bit overflow detect.
// Uses the digit zero code constant of mpt_pkg.
module mpt_digit_acc
    import mpt_pkg::*;
(
    input  logic [31:0] value_in,
    input  logic [7:0]  char_in,
    output logic [31:0] value_out,
    output logic        overflow
);

    logic [35:0] times_ten;
    logic [35:0] sum;
    logic [7:0]  digit;

    // Times ten as times eight plus times two, then add the digit.
    always_comb begin
        digit     = char_in - CHAR_DIGIT_0;
        times_ten = {1'b0, value_in, 3'b000} + {3'b000, value_in, 1'b0};
        sum       = times_ten + {28'd0, digit};
        value_out = sum[31:0];
        overflow  = |sum[35:32];
    end

endmodule

@@ dv/member_path_tokenizer_test.sv @@
// Self-checking testbench for member_path_tokenizer: directed paths, then random
// well-formed, broken and noise paths, checked by a local model or typed words.
// Depends on mpt_pkg and the member_path_tokenizer RTL.
`timescale 1ns / 100ps

module member_path_tokenizer_test;
    import mpt_pkg::*;

    localparam int  CHAR_TARGET    = 500;
    localparam int  IDLE_PCT       = 14;
    localparam int  HOLD_CYCLES    = 60;
    localparam int  WATCHDOG_LIMIT = 1000;
    localparam int  REPORT_LIMIT   = 10;
    localparam logic [2:0] NO_ERROR = 3'd0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  segment_number;
        logic [4:0]  position;
        logic [31:0] payload;
        logic [2:0]  error_code;
    } path_word_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       typed;
        path_word_t word;
    } path_row_t;

    localparam path_word_t NONE = '0;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_in = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [3:0]  m_segment_number;
    logic [4:0]  m_position;
    logic [31:0] m_payload;
    logic [2:0]  m_error_code;

    member_path_tokenizer DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_in        (s_char_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_segment_number (m_segment_number),
        .m_position       (m_position),
        .m_payload        (m_payload),
        .m_error_code     (m_error_code)
    );

    // Directed paths; typed rows carry an expected word that is plain to see.
    path_row_t directed_rows [28] = '{
        '{CHAR_TERM,    1'b1, '{KIND_ERROR, 4'd0, 5'd0, 32'd0, ERR_EMPTY}},
        '{CHAR_OPEN,    1'b1, '{KIND_ERROR, 4'd0, 5'd0, 32'h5B, ERR_LEAD_BRACKET}},
        '{CHAR_TERM,    1'b0, NONE},
        '{8'h61,        1'b0, NONE},
        '{CHAR_CLOSE,   1'b0, NONE},
        '{CHAR_OPEN,    1'b0, NONE},
        '{CHAR_DIGIT_9, 1'b0, NONE},
        '{CHAR_CLOSE,   1'b0, NONE},
        '{CHAR_TERM,    1'b1, '{KIND_DONE, 4'd0, 5'd0, 32'd1, NO_ERROR}},
        '{8'hFF,        1'b1, '{KIND_CHAR, 4'd0, 5'd0, 32'hFF, NO_ERROR}},
        '{CHAR_OPEN,    1'b0, NONE},
        '{CHAR_DIGIT_0, 1'b0, NONE},
        '{CHAR_CLOSE,   1'b0, NONE},
        '{8'h78,        1'b1, '{KIND_ERROR, 4'd0, 5'd0, 32'h78, ERR_AFTER_INDEX}},
        '{CHAR_TERM,    1'b0, NONE},
        '{CHAR_DOT,     1'b1, '{KIND_ERROR, 4'd0, 5'd0, 32'h2E, ERR_BAD_DOT}},
        '{CHAR_TERM,    1'b0, NONE},
        '{8'h71,        1'b0, NONE},
        '{CHAR_OPEN,    1'b0, NONE},
        '{CHAR_TERM,    1'b1, '{KIND_ERROR, 4'd0, 5'd0, 32'd0, ERR_NO_CLOSE}},
        '{8'h71,        1'b0, NONE},
        '{CHAR_OPEN,    1'b0, NONE},
        '{CHAR_CLOSE,   1'b1, '{KIND_ERROR, 4'd0, 5'd0, 32'h5D, ERR_NO_DIGITS}},
        '{CHAR_TERM,    1'b0, NONE},
        '{8'h71,        1'b0, NONE},
        '{CHAR_OPEN,    1'b0, NONE},
        '{8'h2F,        1'b1, '{KIND_ERROR, 4'd0, 5'd0, 32'h2F, ERR_NOT_DIGIT}},
        '{CHAR_TERM,    1'b0, NONE}
    };

    path_word_t  pending_words [$];
    logic [7:0]  path_chars [$];
    int          chars_sent = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          idle_pct = IDLE_PCT;
    int          stall_pct = IDLE_PCT;
    bit          hold_req = 1'b0;
    bit          hold_issued = 1'b0;

    // Parser model state.
    logic [1:0]  parse_mode;
    logic [4:0]  seg_idx;
    logic [5:0]  name_len;
    logic [3:0]  dim_cnt;
    logic [3:0]  digit_cnt;
    logic [31:0] index_acc;

    // Clock.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic void clear_parser();
        parse_mode = MODE_NAME;
        seg_idx    = '0;
        name_len   = '0;
        dim_cnt    = '0;
        digit_cnt  = '0;
        index_acc  = '0;
    endfunction

    function automatic path_word_t make_word(logic [1:0] kind, logic [4:0] pos,
                                             logic [31:0] value, logic [2:0] code);
        path_word_t w;
        w.kind           = kind;
        w.segment_number = seg_idx[3:0];
        w.position       = pos;
        w.payload        = value;
        w.error_code     = code;
        return w;
    endfunction

    // An error on the terminator restarts the parser; otherwise it swallows
    // characters until the next terminator.
    function automatic path_word_t flag_error(logic [7:0] c, logic [2:0] code);
        path_word_t w;
        w = make_word(KIND_ERROR, 5'd0, {24'd0, c}, code);
        if (c == CHAR_TERM) begin
            clear_parser();
        end else begin
            parse_mode = MODE_ERROR;
        end
        return w;
    endfunction

    // Advances the parser model by one character; returns 1 when a word results.
    function automatic logic parse_char(input logic [7:0] c, output path_word_t w);
        logic [63:0] grown;
        w = NONE;
        if (parse_mode == MODE_INDEX) begin
            if (c == CHAR_TERM) begin
                w = flag_error(c, ERR_NO_CLOSE);
                return 1'b1;
            end
            if (c == CHAR_CLOSE) begin
                if (digit_cnt == 0) begin
                    w = flag_error(c, ERR_NO_DIGITS);
                    return 1'b1;
                end
                w = make_word(KIND_INDEX, {1'b0, dim_cnt}, index_acc, NO_ERROR);
                dim_cnt++;
                parse_mode = MODE_NAME;
                return 1'b1;
            end
            if (c > CHAR_DIGIT_9 || c < CHAR_DIGIT_0) begin
                w = flag_error(c, ERR_NOT_DIGIT);
                return 1'b1;
            end
            if (digit_cnt >= DEF_MAX_DIGITS) begin
                w = flag_error(c, ERR_CAPACITY);
                return 1'b1;
            end
            grown = {32'd0, index_acc} * 64'd10 + {56'd0, c - CHAR_DIGIT_0};
            if (grown > 64'hFFFF_FFFF) begin
                w = flag_error(c, ERR_CAPACITY);
                return 1'b1;
            end
            index_acc = grown[31:0];
            digit_cnt++;
            return 1'b0;
        end
        if (parse_mode != MODE_NAME) begin
            if (c == CHAR_TERM) clear_parser();
            return 1'b0;
        end
        if (c == CHAR_TERM) begin
            if (name_len == 0) begin
                w = flag_error(c, ERR_EMPTY);
                return 1'b1;
            end
            w = make_word(KIND_DONE, 5'd0, {27'd0, seg_idx} + 32'd1, NO_ERROR);
            clear_parser();
            return 1'b1;
        end
        if (c == CHAR_DOT) begin
            if (name_len == 0) begin
                w = flag_error(c, ERR_BAD_DOT);
                return 1'b1;
            end
            if (seg_idx + 1 >= DEF_MAX_SEGMENTS) begin
                w = flag_error(c, ERR_CAPACITY);
                return 1'b1;
            end
            seg_idx++;
            name_len = '0;
            dim_cnt  = '0;
            return 1'b0;
        end
        if (c == CHAR_OPEN) begin
            if (name_len == 0) begin
                w = flag_error(c, ERR_LEAD_BRACKET);
                return 1'b1;
            end
            if (dim_cnt >= DEF_MAX_DIMS) begin
                w = flag_error(c, ERR_CAPACITY);
                return 1'b1;
            end
            parse_mode = MODE_INDEX;
            digit_cnt  = '0;
            index_acc  = '0;
            return 1'b0;
        end
        if (dim_cnt != 0) begin
            w = flag_error(c, ERR_AFTER_INDEX);
            return 1'b1;
        end
        if (name_len >= DEF_MAX_NAME_LEN) begin
            w = flag_error(c, ERR_CAPACITY);
            return 1'b1;
        end
        w = make_word(KIND_CHAR, name_len[4:0], {24'd0, c}, NO_ERROR);
        name_len++;
        return 1'b1;
    endfunction

    // Offers one character, waits for it to be taken, then books its word.
    task automatic send_char(input logic [7:0] c, input logic typed, input path_word_t typed_word);
        path_word_t w;
        logic       hit;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_char_in <= c;
        do @(posedge aclk); while (!s_ready);
        hit = parse_char(c, w);
        if (typed) begin
            pending_words.push_back(typed_word);
        end else if (hit) begin
            pending_words.push_back(w);
        end
        chars_sent++;
    endtask

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        if ($urandom_range(9) == 0) return CHAR_CLOSE;
        do c = 8'($urandom_range(1, 255)); while (c == CHAR_DOT || c == CHAR_OPEN);
        return c;
    endfunction

    function automatic logic [7:0] odd_char();
        case ($urandom_range(7))
            0:       return CHAR_TERM;
            1:       return CHAR_DOT;
            2:       return CHAR_OPEN;
            3:       return CHAR_CLOSE;
            4:       return CHAR_DIGIT_0 - 8'd1;
            5:       return CHAR_DIGIT_9 + 8'd1;
            6:       return CHAR_DIGIT_0 + 8'($urandom_range(9));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void push_number(longint unsigned v);
        logic [7:0] digits [$];
        do begin
            digits.push_front(CHAR_DIGIT_0 + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[i]) path_chars.push_back(digits[i]);
    endfunction

    // Index digits: mostly short, sometimes at or just over the width limits.
    function automatic void push_digits();
        int roll;
        roll = $urandom_range(99);
        if (roll < 3) begin
            push_number(64'hFFFF_FFFF);
        end else if (roll < 6) begin
            push_number(64'h1_0000_0000);
        end else begin
            repeat ((roll < 10) ? $urandom_range(10, 11) : $urandom_range(1, 3))
                path_chars.push_back(CHAR_DIGIT_0 + 8'($urandom_range(9)));
        end
    endfunction

    // Builds one terminated path: mostly well formed, some broken, a few noise.
    function automatic void build_path();
        int roll;
        int n_seg;
        int cut;
        path_chars.delete();
        roll = $urandom_range(99);
        if (roll < 6) begin
            repeat ($urandom_range(1, 8))
                path_chars.push_back($urandom_range(1) ? odd_char() : 8'($urandom_range(255)));
            path_chars.push_back(CHAR_TERM);
            return;
        end
        n_seg = ($urandom_range(99) < 4) ? $urandom_range(15, 17) : $urandom_range(1, 3);
        for (int s = 0; s < n_seg; s++) begin
            if (s > 0) path_chars.push_back(CHAR_DOT);
            repeat (($urandom_range(99) < 4) ? $urandom_range(31, 33) : $urandom_range(1, 4))
                path_chars.push_back(name_char());
            repeat (($urandom_range(99) < 5) ? $urandom_range(8, 9) : $urandom_range(0, 2)) begin
                path_chars.push_back(CHAR_OPEN);
                push_digits();
                path_chars.push_back(CHAR_CLOSE);
            end
        end
        path_chars.push_back(CHAR_TERM);
        if (roll >= 26) return;
        // Break the path in one place.
        cut = $urandom_range(path_chars.size() - 2);
        case ($urandom_range(3))
            0: path_chars[cut] = odd_char();
            1: begin
                while (path_chars.size() > cut + 1) void'(path_chars.pop_back());
                path_chars.push_back(CHAR_TERM);
            end
            2: begin
                void'(path_chars.pop_back());
                path_chars.push_back(CHAR_DOT);
                path_chars.push_back(CHAR_TERM);
            end
            default: path_chars.push_front(CHAR_DOT);
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic void note_mismatch(string what, path_word_t want, path_word_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%t: %s: want kind %0d seg %0d pos %0d payload %h code %0d",
                     $realtime, what, want.kind, want.segment_number, want.position,
                     want.payload, want.error_code);
            $display("%t: %s: got  kind %0d seg %0d pos %0d payload %h code %0d",
                     $realtime, what, got.kind, got.segment_number, got.position,
                     got.payload, got.error_code);
        end
    endfunction

    // Compare each result word with the oldest booked word.
    always @(posedge aclk) begin : check_words
        path_word_t got;
        path_word_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_kind, m_segment_number, m_position, m_payload, m_error_code};
            if (pending_words.size() == 0) begin
                note_mismatch("word with none booked", NONE, got);
            end else begin
                want = pending_words.pop_front();
                if (got.kind !== want.kind || got.segment_number !== want.segment_number ||
                    got.position !== want.position || got.payload !== want.payload ||
                    got.error_code !== want.error_code)
                    note_mismatch("word mismatch", want, got);
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL member_path_tokenizer");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Reset, directed rows, random paths, then drain and report.
    initial begin
        clear_parser();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i])
            send_char(directed_rows[i].char_in, directed_rows[i].typed, directed_rows[i].word);
        while (chars_sent < CHAR_TARGET) begin
            build_path();
            foreach (path_chars[i]) begin
                // A quiet stretch with one long receiver hold-off inside it.
                if (chars_sent >= 200 && chars_sent < 320) begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end else begin
                    idle_pct  = IDLE_PCT;
                    stall_pct = IDLE_PCT;
                end
                if (chars_sent >= 250 && !hold_issued) begin
                    hold_issued = 1'b1;
                    hold_req    = 1'b1;
                end
                send_char(path_chars[i], 1'b0, NONE);
            end
        end
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS member_path_tokenizer");
        end else begin
            $display("FAIL member_path_tokenizer");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/mpt_pkg.sv
hdl/mpt_digit_acc.sv
hdl/member_path_tokenizer.sv
dv/member_path_tokenizer_test.sv
